// File: src/arpre_pkg.sv
package arpre_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] hop_ip;
    logic [15:0] buffer_tag;
    logic [47:0] frame_dst_mac;
    logic [15:0] frame_ethertype;
    logic        payload_ok;
    logic [15:0] arp_op;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_sender_ip;
    logic [31:0] arp_target_ip;
    logic [15:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [47:0] dest_mac;
    logic [31:0] arp_target_ip_out;
    logic [47:0] arp_target_mac_out;
    logic [15:0] tag_out;
    logic        last;
  } result_t;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_RECV = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [2:0] RES_IPV4    = 3'd0;
  localparam logic [2:0] RES_REQUEST = 3'd1;
  localparam logic [2:0] RES_REPLY   = 3'd2;
  localparam logic [2:0] RES_DELIVER = 3'd3;
  localparam logic [2:0] RES_DROP    = 3'd4;

  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [15:0] ETYPE_ARP      = 16'h0806;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

  localparam logic [30:0] LIFETIME_RESET = 31'd30000;
  localparam logic [30:0] RETRY_RESET    = 31'd5000;

  localparam logic [1:0] REG_OWN_MAC  = 2'd0;
  localparam logic [1:0] REG_OWN_IP   = 2'd1;
  localparam logic [1:0] REG_LIFETIME = 2'd2;
  localparam logic [1:0] REG_RETRY    = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEND,
    OP_DELIVER,
    OP_ARP,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        reply;
    logic [31:0] ip;
    logic [15:0] tag;
    logic [47:0] mac;
    logic [15:0] elapsed;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEND_SCAN,
    S_SEND_DONE,
    S_DELIVER,
    S_LEARN_SCAN,
    S_LEARN_DONE,
    S_FLUSH_SCAN,
    S_FLUSH_DONE,
    S_TICK_SCAN,
    S_FINISH
  } state_t;

endpackage

// File: src/arpre_front.sv
module arpre_front import arpre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  item_t       item,
  output logic        busy,
  input  logic [47:0] own_mac,
  input  logic [31:0] own_ip,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_pop
);

  job_t       q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] cnt;
  job_t       cls;
  logic       push;

  always_comb begin
    cls = '0;
    cls.tag = item.buffer_tag;
    cls.elapsed = item.elapsed_ms;
    cls.mac = item.arp_sender_mac;
    cls.ip = item.arp_sender_ip;
    cls.reply = (item.arp_op == ARP_OP_REQUEST) && (item.arp_target_ip == own_ip);
    case (item.kind)
      KIND_SEND: begin
        cls.op = OP_SEND;
        cls.ip = item.hop_ip;
      end
      KIND_RECV: begin
        // drop foreign destinations and bad payloads
        if ((item.frame_dst_mac == own_mac || item.frame_dst_mac == MAC_BCAST) &&
            item.payload_ok) begin
          if (item.frame_ethertype == ETYPE_IPV4) cls.op = OP_DELIVER;
          else if (item.frame_ethertype == ETYPE_ARP) cls.op = OP_ARP;
          else cls.op = OP_NONE;
        end else begin
          cls.op = OP_NONE;
        end
      end
      KIND_TICK: cls.op = OP_TICK;
      default:   cls.op = OP_NONE;
    endcase
  end

  assign busy = (cnt == 2'd2);
  assign push = start && !busy;
  assign job_valid = (cnt != 2'd0);
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        q[wr_ptr] <= cls;
        wr_ptr <= !wr_ptr;
      end
      if (job_pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + 2'(push) - 2'(job_pop);
    end
  end

endmodule

// File: src/arpre_back.sv
module arpre_back import arpre_pkg::*; #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 8,
  parameter int WAIT_SLOTS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  input  logic [30:0] lifetime,
  input  logic [30:0] retry,
  output logic        result_valid,
  output result_t     result
);

  localparam int CIW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PIW  = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int WIW  = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int OW   = $clog2(WAIT_SLOTS + 1);
  localparam int MAXD = (CACHE_ENTRIES > PENDING_ENTRIES) ?
                        ((CACHE_ENTRIES > WAIT_SLOTS) ? CACHE_ENTRIES : WAIT_SLOTS) :
                        ((PENDING_ENTRIES > WAIT_SLOTS) ? PENDING_ENTRIES : WAIT_SLOTS);
  localparam int KW   = $clog2(MAXD + 1);

  state_t state, state_next;
  job_t   cur;
  logic [31:0] now;
  logic [KW-1:0] k;

  logic [CACHE_ENTRIES-1:0]   cv;
  logic [31:0] cip    [CACHE_ENTRIES];
  logic [47:0] cmac   [CACHE_ENTRIES];
  logic [31:0] cstamp [CACHE_ENTRIES];
  logic [PENDING_ENTRIES-1:0] pv;
  logic [31:0] pip    [PENDING_ENTRIES];
  logic [31:0] pstamp [PENDING_ENTRIES];
  logic [WAIT_SLOTS-1:0]      wv;
  logic [31:0] wip    [WAIT_SLOTS];
  logic [15:0] wtag   [WAIT_SLOTS];
  logic [OW-1:0] word [WAIT_SLOTS];

  // scan accumulators
  logic          hit;
  logic [47:0]   hit_mac;
  logic          wsf;
  logic [WIW-1:0] ws;
  logic [OW-1:0] wcnt;
  logic          pmatch;
  logic          pff;
  logic [PIW-1:0] pfs;
  logic          cmf;
  logic [CIW-1:0] cms;
  logic          cff;
  logic [CIW-1:0] cfs;
  logic [31:0]   best_age;
  logic [CIW-1:0] best_slot;
  logic          ffound;
  logic [WIW-1:0] fidx;
  logic [OW-1:0] ford;
  logic [15:0]   ftag;

  logic        hv;
  result_t     hres;
  result_t     fin_r;
  logic        emit_v;
  result_t     emit_r;

  logic [CIW-1:0] kc;
  logic [PIW-1:0] kp;
  logic [WIW-1:0] kw;
  logic in_c, in_p, in_w, scan_end;
  logic [31:0] cage, page;
  logic [CIW-1:0] lslot;
  logic send_drop;

  assign kc = k[CIW-1:0];
  assign kp = k[PIW-1:0];
  assign kw = k[WIW-1:0];
  assign in_c = (k < KW'(CACHE_ENTRIES));
  assign in_p = (k < KW'(PENDING_ENTRIES));
  assign in_w = (k < KW'(WAIT_SLOTS));
  assign scan_end = (k == KW'(MAXD - 1));
  assign cage = now - cstamp[kc];
  assign page = now - pstamp[kp];
  assign lslot = cmf ? cms : (cff ? cfs : best_slot);
  assign send_drop = !wsf || (!pmatch && !pff);
  assign job_pop = (state == S_IDLE) && job_valid;

  always_comb begin
    fin_r = hres;
    fin_r.last = 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          unique case (job.op)
            OP_SEND:    state_next = S_SEND_SCAN;
            OP_DELIVER: state_next = S_DELIVER;
            OP_ARP:     state_next = S_LEARN_SCAN;
            OP_TICK:    state_next = S_TICK_SCAN;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SEND_SCAN:  if (scan_end) state_next = S_SEND_DONE;
      S_SEND_DONE:  state_next = S_FINISH;
      S_DELIVER:    state_next = S_FINISH;
      S_LEARN_SCAN: if (scan_end) state_next = S_LEARN_DONE;
      S_LEARN_DONE: state_next = S_FLUSH_SCAN;
      S_FLUSH_SCAN: if (scan_end) state_next = S_FLUSH_DONE;
      S_FLUSH_DONE: state_next = ffound ? S_FLUSH_SCAN : S_FINISH;
      S_TICK_SCAN:  if (scan_end) state_next = S_FINISH;
      S_FINISH:     state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit_v = 1'b0;
    emit_r = '0;
    unique case (state)
      S_SEND_DONE: begin
        emit_r.tag_out = cur.tag;
        if (hit) begin
          emit_v = 1'b1;
          emit_r.result_kind = RES_IPV4;
          emit_r.dest_mac = hit_mac;
        end else if (send_drop) begin
          emit_v = 1'b1;
          emit_r.result_kind = RES_DROP;
        end else if (!pmatch) begin
          emit_v = 1'b1;
          emit_r.result_kind = RES_REQUEST;
          emit_r.dest_mac = MAC_BCAST;
          emit_r.arp_target_ip_out = cur.ip;
          emit_r.tag_out = '0;
        end
      end
      S_DELIVER: begin
        emit_v = 1'b1;
        emit_r.result_kind = RES_DELIVER;
        emit_r.tag_out = cur.tag;
      end
      S_LEARN_DONE: begin
        if (cur.reply) begin
          emit_v = 1'b1;
          emit_r.result_kind = RES_REPLY;
          emit_r.dest_mac = cur.mac;
          emit_r.arp_target_ip_out = cur.ip;
          emit_r.arp_target_mac_out = cur.mac;
        end
      end
      S_FLUSH_DONE: begin
        if (ffound) begin
          emit_v = 1'b1;
          emit_r.result_kind = RES_IPV4;
          emit_r.dest_mac = cur.mac;
          emit_r.tag_out = ftag;
        end
      end
      S_TICK_SCAN: begin
        if (in_p && pv[kp] && page >= {1'b0, retry}) begin
          emit_v = 1'b1;
          emit_r.result_kind = RES_REQUEST;
          emit_r.dest_mac = MAC_BCAST;
          emit_r.arp_target_ip_out = pip[kp];
        end
      end
      default: emit_v = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      now <= '0;
      k <= '0;
      cv <= '0;
      pv <= '0;
      wv <= '0;
      hv <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;

      // hold each result one step so the final one can carry last
      if (emit_v) begin
        if (hv) begin
          result_valid <= 1'b1;
          result <= hres;
        end
        hres <= emit_r;
        hv <= 1'b1;
      end else if (state == S_FINISH && hv) begin
        result_valid <= 1'b1;
        result <= fin_r;
        hv <= 1'b0;
      end

      if (state == S_SEND_SCAN || state == S_LEARN_SCAN ||
          state == S_FLUSH_SCAN || state == S_TICK_SCAN) begin
        k <= scan_end ? '0 : k + KW'(1);
      end else begin
        k <= '0;
        hit <= 1'b0;
        wsf <= 1'b0;
        wcnt <= '0;
        pmatch <= 1'b0;
        pff <= 1'b0;
        cmf <= 1'b0;
        cff <= 1'b0;
        best_age <= '0;
        best_slot <= '0;
        ffound <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            if (job.op == OP_TICK) now <= now + 32'(job.elapsed);
          end
        end
        S_SEND_SCAN: begin
          if (in_c && cv[kc] && cip[kc] == cur.ip && !hit) begin
            hit <= 1'b1;
            hit_mac <= cmac[kc];
          end
          if (in_w) begin
            if (wv[kw]) wcnt <= wcnt + OW'(1);
            else if (!wsf) begin
              wsf <= 1'b1;
              ws <= kw;
            end
          end
          if (in_p) begin
            if (pv[kp] && pip[kp] == cur.ip) pmatch <= 1'b1;
            else if (!pv[kp] && !pff) begin
              pff <= 1'b1;
              pfs <= kp;
            end
          end
        end
        S_SEND_DONE: begin
          if (!hit && !send_drop) begin
            wv[ws] <= 1'b1;
            wip[ws] <= cur.ip;
            wtag[ws] <= cur.tag;
            word[ws] <= wcnt;
            if (!pmatch) begin
              pv[pfs] <= 1'b1;
              pip[pfs] <= cur.ip;
              pstamp[pfs] <= now;
            end
          end
        end
        S_LEARN_SCAN: begin
          if (in_c) begin
            if (cv[kc] && cip[kc] == cur.ip && !cmf) begin
              cmf <= 1'b1;
              cms <= kc;
            end
            if (!cv[kc] && !cff) begin
              cff <= 1'b1;
              cfs <= kc;
            end
            if (cage > best_age) begin
              best_age <= cage;
              best_slot <= kc;
            end
          end
          if (in_p && pv[kp] && pip[kp] == cur.ip) pv[kp] <= 1'b0;
        end
        S_LEARN_DONE: begin
          cv[lslot] <= 1'b1;
          cip[lslot] <= cur.ip;
          cmac[lslot] <= cur.mac;
          cstamp[lslot] <= now;
        end
        S_FLUSH_SCAN: begin
          if (in_w && wv[kw] && wip[kw] == cur.ip && (!ffound || word[kw] < ford)) begin
            ffound <= 1'b1;
            fidx <= kw;
            ford <= word[kw];
            ftag <= wtag[kw];
          end
        end
        S_FLUSH_DONE: begin
          if (ffound) begin
            // close up the ranks behind the removed slot
            for (int i = 0; i < WAIT_SLOTS; i++) begin
              if (wv[i] && word[i] > ford) word[i] <= word[i] - OW'(1);
            end
            wv[fidx] <= 1'b0;
          end
        end
        S_TICK_SCAN: begin
          if (in_c && cv[kc] && cage > {1'b0, lifetime}) cv[kc] <= 1'b0;
          if (in_p && pv[kp] && page >= {1'b0, retry}) pstamp[kp] <= now;
        end
        default: ;
      endcase
    end
  end

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.result_kind <= RES_DROP))
    else $error("result kind out of range");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hv)
    else $error("held result left over in idle");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && hv) |=> (result_valid && result.last))
    else $error("final result not marked last");

endmodule

// File: src/arp_resolution_engine_unit.sv
// A scan visits one table entry a cycle over max(CACHE_ENTRIES, PENDING_ENTRIES,
// WAIT_SLOTS) entries. Send and tick items take one scan, IPv4 deliveries none;
// ARP frames take one learn scan plus one flush scan per flushed datagram and a
// final flush scan that finds none; a 2-deep queue buffers items.
// Results come one per cycle at most and cannot be stalled by the receiver.
// Reset (rst, synchronous) empties cache, pending and wait tables and the clock.
module arp_resolution_engine_unit import arpre_pkg::*; #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 8,
  parameter int WAIT_SLOTS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        result_valid,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic [30:0] lifetime;
  logic [30:0] retry;
  logic        job_valid;
  job_t        job;
  logic        job_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      own_ip <= '0;
      lifetime <= LIFETIME_RESET;
      retry <= RETRY_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:3])
        REG_OWN_MAC:  own_mac <= pwdata[47:0];
        REG_OWN_IP:   own_ip <= pwdata[31:0];
        REG_LIFETIME: lifetime <= pwdata[30:0];
        REG_RETRY:    retry <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_OWN_MAC:  prdata = {16'd0, own_mac};
      REG_OWN_IP:   prdata = {32'd0, own_ip};
      REG_LIFETIME: prdata = {33'd0, lifetime};
      REG_RETRY:    prdata = {33'd0, retry};
      default:      prdata = '0;
    endcase
  end

  arpre_front u_front (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .own_mac(own_mac), .own_ip(own_ip),
    .job_valid(job_valid), .job(job), .job_pop(job_pop)
  );

  arpre_back #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .PENDING_ENTRIES(PENDING_ENTRIES),
    .WAIT_SLOTS(WAIT_SLOTS)
  ) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job), .job_pop(job_pop),
    .lifetime(lifetime), .retry(retry),
    .result_valid(result_valid), .result(result)
  );

endmodule

// File: tb/sv/arp_resolution_engine_unit_test.sv
`timescale 1ns / 100ps

module arp_resolution_engine_unit_test;
  import arpre_pkg::*;

  localparam int N_CACHE = 16;
  localparam int N_PEND  = 8;
  localparam int N_WAIT  = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        result_valid;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  arp_resolution_engine_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // resolver model state
  logic [47:0] mdl_mac;
  logic [31:0] mdl_ip;
  logic [30:0] mdl_lifetime;
  logic [30:0] mdl_retry;
  logic [31:0] now_ms;
  bit          arp_valid [N_CACHE];
  logic [31:0] arp_ip    [N_CACHE];
  logic [47:0] arp_mac   [N_CACHE];
  logic [31:0] arp_stamp [N_CACHE];
  bit          req_valid [N_PEND];
  logic [31:0] req_ip    [N_PEND];
  logic [31:0] req_stamp [N_PEND];
  bit          hold_valid [N_WAIT];
  logic [31:0] hold_ip    [N_WAIT];
  logic [15:0] hold_tag   [N_WAIT];
  int          hold_rank  [N_WAIT];

  item_t   pending_items [$];
  result_t frames_due [$];
  result_t step_frames [$];
  logic [31:0] ip_pool [24];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    $display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $realtime);
  endtask

  function automatic void add_frame(logic [2:0] k, logic [47:0] dm, logic [31:0] tip,
                                    logic [47:0] tm, logic [15:0] tag);
    result_t r;
    r.result_kind = k;
    r.dest_mac = dm;
    r.arp_target_ip_out = tip;
    r.arp_target_mac_out = tm;
    r.tag_out = tag;
    r.last = 1'b0;
    step_frames.insert(step_frames.size(), r);
  endfunction

  function automatic int find_arp(logic [31:0] ip);
    for (int i = 0; i < N_CACHE; i++)
      if (arp_valid[i] && arp_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int find_req(logic [31:0] ip);
    for (int i = 0; i < N_PEND; i++)
      if (req_valid[i] && req_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic void learn_mapping(logic [31:0] ip, logic [47:0] mac);
    int slot;
    logic [31:0] oldest, age;
    slot = find_arp(ip);
    for (int i = 0; i < N_CACHE && slot < 0; i++)
      if (!arp_valid[i]) slot = i;
    if (slot < 0) begin
      // evict the oldest, lowest index on a tie
      oldest = 0;
      slot = 0;
      for (int i = 0; i < N_CACHE; i++) begin
        age = now_ms - arp_stamp[i];
        if (age > oldest) begin
          oldest = age;
          slot = i;
        end
      end
    end
    arp_valid[slot] = 1'b1;
    arp_ip[slot] = ip;
    arp_mac[slot] = mac;
    arp_stamp[slot] = now_ms;
  endfunction

  function automatic void route_datagram(logic [31:0] ip, logic [15:0] tag);
    int c, ws, ps, count;
    bit fresh;
    c = find_arp(ip);
    if (c >= 0) begin
      add_frame(RES_IPV4, arp_mac[c], '0, '0, tag);
      return;
    end
    ws = -1;
    count = 0;
    for (int i = 0; i < N_WAIT; i++) begin
      if (hold_valid[i]) count++;
      else if (ws < 0) ws = i;
    end
    ps = find_req(ip);
    fresh = (ps < 0);
    for (int i = 0; i < N_PEND && ps < 0; i++)
      if (!req_valid[i]) ps = i;
    if (ws < 0 || ps < 0) begin
      add_frame(RES_DROP, '0, '0, '0, tag);
      return;
    end
    hold_valid[ws] = 1'b1;
    hold_ip[ws] = ip;
    hold_tag[ws] = tag;
    hold_rank[ws] = count;
    if (fresh) begin
      req_valid[ps] = 1'b1;
      req_ip[ps] = ip;
      req_stamp[ps] = now_ms;
      add_frame(RES_REQUEST, MAC_BCAST, ip, '0, '0);
    end
  endfunction

  function automatic void receive_frame(item_t it);
    int p, oldest, r;
    logic [15:0] t;
    if (it.frame_dst_mac != mdl_mac && it.frame_dst_mac != MAC_BCAST) return;
    if (!it.payload_ok) return;
    if (it.frame_ethertype == ETYPE_IPV4) begin
      add_frame(RES_DELIVER, '0, '0, '0, it.buffer_tag);
      return;
    end
    if (it.frame_ethertype != ETYPE_ARP) return;
    learn_mapping(it.arp_sender_ip, it.arp_sender_mac);
    if (it.arp_op == ARP_OP_REQUEST && it.arp_target_ip == mdl_ip)
      add_frame(RES_REPLY, it.arp_sender_mac, it.arp_sender_ip, it.arp_sender_mac, '0);
    p = find_req(it.arp_sender_ip);
    if (p >= 0) req_valid[p] = 1'b0;
    // flush queued datagrams for this address, oldest first
    forever begin
      oldest = -1;
      for (int i = 0; i < N_WAIT; i++)
        if (hold_valid[i] && hold_ip[i] == it.arp_sender_ip &&
            (oldest < 0 || hold_rank[i] < hold_rank[oldest])) oldest = i;
      if (oldest < 0) break;
      t = hold_tag[oldest];
      r = hold_rank[oldest];
      hold_valid[oldest] = 1'b0;
      for (int i = 0; i < N_WAIT; i++)
        if (hold_valid[i] && hold_rank[i] > r) hold_rank[i]--;
      route_datagram(it.arp_sender_ip, t);
    end
  endfunction

  function automatic void advance_clock(logic [15:0] elapsed);
    now_ms += 32'(elapsed);
    for (int i = 0; i < N_CACHE; i++)
      if (arp_valid[i] && (now_ms - arp_stamp[i]) > {1'b0, mdl_lifetime})
        arp_valid[i] = 1'b0;
    for (int i = 0; i < N_PEND; i++)
      if (req_valid[i] && (now_ms - req_stamp[i]) >= {1'b0, mdl_retry}) begin
        add_frame(RES_REQUEST, MAC_BCAST, req_ip[i], '0, '0);
        req_stamp[i] = now_ms;
      end
  endfunction

  function automatic void resolve_item(item_t it);
    step_frames.delete();
    case (it.kind)
      KIND_SEND: route_datagram(it.hop_ip, it.buffer_tag);
      KIND_RECV: receive_frame(it);
      KIND_TICK: advance_clock(it.elapsed_ms);
      default: ;
    endcase
    if (step_frames.size() > 0) step_frames[step_frames.size() - 1].last = 1'b1;
    foreach (step_frames[i]) frames_due.insert(frames_due.size(), step_frames[i]);
  endfunction

  // driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        resolve_item(item);
        items_sent++;
        idle_cycles = 0;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item <= pending_items.pop_front();
          start <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, check each on arrival
  result_t want;
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      results_seen++;
      idle_cycles = 0;
      if (frames_due.size() == 0) begin
        report_mismatch("result with nothing expected", '0, 64'(result.result_kind));
      end else begin
        want = frames_due.pop_front();
        if (result.result_kind !== want.result_kind)
          report_mismatch("result_kind", 64'(want.result_kind), 64'(result.result_kind));
        if (result.dest_mac !== want.dest_mac)
          report_mismatch("dest_mac", 64'(want.dest_mac), 64'(result.dest_mac));
        if (result.arp_target_ip_out !== want.arp_target_ip_out)
          report_mismatch("arp_target_ip_out", 64'(want.arp_target_ip_out),
                          64'(result.arp_target_ip_out));
        if (result.arp_target_mac_out !== want.arp_target_mac_out)
          report_mismatch("arp_target_mac_out", 64'(want.arp_target_mac_out),
                          64'(result.arp_target_mac_out));
        if (result.tag_out !== want.tag_out)
          report_mismatch("tag_out", 64'(want.tag_out), 64'(result.tag_out));
        if (result.last !== want.last)
          report_mismatch("last", 64'(want.last), 64'(result.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    idle_cycles = 0;
    case (idx)
      REG_OWN_MAC:  mdl_mac = value[47:0];
      REG_OWN_IP:   mdl_ip = value[31:0];
      REG_LIFETIME: mdl_lifetime = value[30:0];
      REG_RETRY:    mdl_retry = value[30:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_items.size() > 0 || start || frames_due.size() > 0) @(posedge clk);
    // ticks and dropped frames may still be scanning with no result due
    repeat (150) @(posedge clk);
  endtask

  function automatic item_t random_item();
    item_t it;
    logic [319:0] raw;
    int r;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < 35) begin
      it.kind = KIND_SEND;
      it.hop_ip = ip_pool[$urandom_range(0, 11)];
    end else if (r < 70) begin
      it.kind = KIND_RECV;
      case ($urandom_range(0, 9))
        0: ;
        1, 2, 3: it.frame_dst_mac = MAC_BCAST;
        default: it.frame_dst_mac = mdl_mac;
      endcase
      it.frame_ethertype = ETYPE_ARP;
      it.payload_ok = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 19) != 0) it.arp_op = 16'($urandom_range(1, 2));
      it.arp_sender_ip = ip_pool[$urandom_range(0, 23)];
      if ($urandom_range(0, 1)) it.arp_target_ip = mdl_ip;
    end else if (r < 78) begin
      it.kind = KIND_RECV;
      it.frame_dst_mac = $urandom_range(0, 1) ? MAC_BCAST : mdl_mac;
      it.frame_ethertype = ETYPE_IPV4;
    end else if (r < 92) begin
      it.kind = KIND_TICK;
      if ($urandom_range(0, 9) != 0)
        it.elapsed_ms = 16'((mdl_retry > 20000) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 3 * mdl_retry));
    end else if (r < 98) begin
      it.kind = 2'($urandom_range(0, 3));
    end else begin
      it.kind = 2'd3;
    end
    return it;
  endfunction

  task automatic queue_item(item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic queue_random(int count);
    repeat (count) queue_item(random_item());
  endtask

  task automatic queue_directed;
    item_t it;
    it = '0;
    // unresolved next hop: request, then queued silently
    it.kind = KIND_SEND; it.hop_ip = ip_pool[0]; it.buffer_tag = 16'h0000;
    queue_item(it);
    it.buffer_tag = 16'hFFFF;
    queue_item(it);
    // fill the pending table, then one more drops
    for (int i = 1; i <= 8; i++) begin
      it.hop_ip = ip_pool[i]; it.buffer_tag = 16'h0100 + 16'(i);
      queue_item(it);
    end
    // reply resolves the first address and flushes in order
    it = '0;
    it.kind = KIND_RECV; it.frame_dst_mac = mdl_mac; it.frame_ethertype = ETYPE_ARP;
    it.payload_ok = 1'b1; it.arp_op = 16'd2; it.arp_sender_mac = 48'hFFFF_FFFF_FFFF;
    it.arp_sender_ip = ip_pool[0]; it.arp_target_ip = mdl_ip;
    queue_item(it);
    // request for our address gets a reply
    it.frame_dst_mac = MAC_BCAST; it.arp_op = ARP_OP_REQUEST;
    it.arp_sender_mac = 48'h0000_0000_0001; it.arp_sender_ip = ip_pool[1];
    queue_item(it);
    // odd opcode still teaches the sender
    it.arp_op = 16'hFFFF; it.arp_sender_ip = 32'hFFFF_FFFF; it.arp_sender_mac = '0;
    queue_item(it);
    it = '0;
    it.kind = KIND_SEND; it.hop_ip = ip_pool[0]; it.buffer_tag = 16'h1234;
    queue_item(it);
    // plain IPv4 delivery, bad payload, foreign MAC, unknown type
    it = '0;
    it.kind = KIND_RECV; it.frame_dst_mac = mdl_mac; it.frame_ethertype = ETYPE_IPV4;
    it.payload_ok = 1'b1; it.buffer_tag = 16'hBEEF;
    queue_item(it);
    it.payload_ok = 1'b0;
    queue_item(it);
    it.payload_ok = 1'b1; it.frame_dst_mac = mdl_mac ^ 48'h1;
    queue_item(it);
    it.frame_dst_mac = mdl_mac; it.frame_ethertype = 16'h86DD;
    queue_item(it);
    it = '0;
    it.kind = 2'd3;
    queue_item(it);
    // zero tick, then the longest tick: resend and expire
    it = '0;
    it.kind = KIND_TICK;
    queue_item(it);
    it.elapsed_ms = 16'hFFFF;
    queue_item(it);
    it = '0;
    it.kind = KIND_SEND; it.hop_ip = ip_pool[0]; it.buffer_tag = 16'h0042;
    queue_item(it);
  endtask

  initial begin
    mdl_mac = '0;
    mdl_ip = '0;
    mdl_lifetime = LIFETIME_RESET;
    mdl_retry = RETRY_RESET;
    now_ms = '0;
    foreach (arp_valid[i]) arp_valid[i] = 1'b0;
    foreach (req_valid[i]) req_valid[i] = 1'b0;
    foreach (hold_valid[i]) hold_valid[i] = 1'b0;
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_OWN_MAC, {$urandom, $urandom});
    write_reg(REG_OWN_IP, 64'($urandom));
    settings_used++;
    queue_directed();
    queue_random(45);
    drain();

    write_reg(REG_LIFETIME, 64'd1);
    write_reg(REG_RETRY, 64'd1);
    write_reg(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_OWN_IP, 64'd0);
    settings_used++;
    queue_random(35);
    drain();

    write_reg(REG_LIFETIME, 64'h7FFF_FFFF);
    write_reg(REG_RETRY, 64'h7FFF_FFFF);
    write_reg(REG_OWN_MAC, {$urandom, $urandom});
    write_reg(REG_OWN_IP, 64'hFFFF_FFFF);
    settings_used++;
    queue_random(30);
    drain();

    write_reg(REG_LIFETIME, 64'd200);
    write_reg(REG_RETRY, 64'd50);
    settings_used++;
    queue_random(30);
    drain();

    $display("Ran %0d items over %0d register settings, %0d results checked",
             items_sent, settings_used, results_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
